[rtl/kuz_pkg.sv]
// Package for the Kuznyechik block cipher: types, S-boxes and the linear map L.
// Used by every module in rtl/; no dependencies.
package kuz_pkg;

  typedef logic [127:0] blk_t;

  localparam int unsigned NumRounds = 9;
  localparam int unsigned NumRk     = 10;
  localparam int unsigned NumKsRounds = 32;
  localparam int unsigned AddrW     = 5;

  localparam logic [AddrW-1:0] AddrKey0 = 5'd0;
  localparam logic [AddrW-1:0] AddrKey1 = 5'd8;
  localparam logic [AddrW-1:0] AddrKey2 = 5'd16;
  localparam logic [AddrW-1:0] AddrKey3 = 5'd24;

  localparam logic REQ_ENC = 1'b0;
  localparam logic REQ_DEC = 1'b1;

  localparam logic [7:0] SBOX [256] = '{
    8'hfc,8'hee,8'hdd,8'h11,8'hcf,8'h6e,8'h31,8'h16,8'hfb,8'hc4,8'hfa,8'hda,8'h23,8'hc5,8'h04,8'h4d,
    8'he9,8'h77,8'hf0,8'hdb,8'h93,8'h2e,8'h99,8'hba,8'h17,8'h36,8'hf1,8'hbb,8'h14,8'hcd,8'h5f,8'hc1,
    8'hf9,8'h18,8'h65,8'h5a,8'he2,8'h5c,8'hef,8'h21,8'h81,8'h1c,8'h3c,8'h42,8'h8b,8'h01,8'h8e,8'h4f,
    8'h05,8'h84,8'h02,8'hae,8'he3,8'h6a,8'h8f,8'ha0,8'h06,8'h0b,8'hed,8'h98,8'h7f,8'hd4,8'hd3,8'h1f,
    8'heb,8'h34,8'h2c,8'h51,8'hea,8'hc8,8'h48,8'hab,8'hf2,8'h2a,8'h68,8'ha2,8'hfd,8'h3a,8'hce,8'hcc,
    8'hb5,8'h70,8'h0e,8'h56,8'h08,8'h0c,8'h76,8'h12,8'hbf,8'h72,8'h13,8'h47,8'h9c,8'hb7,8'h5d,8'h87,
    8'h15,8'ha1,8'h96,8'h29,8'h10,8'h7b,8'h9a,8'hc7,8'hf3,8'h91,8'h78,8'h6f,8'h9d,8'h9e,8'hb2,8'hb1,
    8'h32,8'h75,8'h19,8'h3d,8'hff,8'h35,8'h8a,8'h7e,8'h6d,8'h54,8'hc6,8'h80,8'hc3,8'hbd,8'h0d,8'h57,
    8'hdf,8'hf5,8'h24,8'ha9,8'h3e,8'ha8,8'h43,8'hc9,8'hd7,8'h79,8'hd6,8'hf6,8'h7c,8'h22,8'hb9,8'h03,
    8'he0,8'h0f,8'hec,8'hde,8'h7a,8'h94,8'hb0,8'hbc,8'hdc,8'he8,8'h28,8'h50,8'h4e,8'h33,8'h0a,8'h4a,
    8'ha7,8'h97,8'h60,8'h73,8'h1e,8'h00,8'h62,8'h44,8'h1a,8'hb8,8'h38,8'h82,8'h64,8'h9f,8'h26,8'h41,
    8'had,8'h45,8'h46,8'h92,8'h27,8'h5e,8'h55,8'h2f,8'h8c,8'ha3,8'ha5,8'h7d,8'h69,8'hd5,8'h95,8'h3b,
    8'h07,8'h58,8'hb3,8'h40,8'h86,8'hac,8'h1d,8'hf7,8'h30,8'h37,8'h6b,8'he4,8'h88,8'hd9,8'he7,8'h89,
    8'he1,8'h1b,8'h83,8'h49,8'h4c,8'h3f,8'hf8,8'hfe,8'h8d,8'h53,8'haa,8'h90,8'hca,8'hd8,8'h85,8'h61,
    8'h20,8'h71,8'h67,8'ha4,8'h2d,8'h2b,8'h09,8'h5b,8'hcb,8'h9b,8'h25,8'hd0,8'hbe,8'he5,8'h6c,8'h52,
    8'h59,8'ha6,8'h74,8'hd2,8'he6,8'hf4,8'hb4,8'hc0,8'hd1,8'h66,8'haf,8'hc2,8'h39,8'h4b,8'h63,8'hb6
  };

  localparam logic [7:0] LCOEF [16] = '{
    8'h94,8'h20,8'h85,8'h10,8'hc2,8'hc0,8'h01,8'hfb,
    8'h01,8'hc0,8'hc2,8'h10,8'h85,8'h20,8'h94,8'h01
  };

  function automatic logic [7:0] sbox_inv(input logic [7:0] y);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 256; i++) begin
      if (SBOX[i] == y) r = 8'(i);
    end
    return r;
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] acc;
    logic [7:0] a;
    acc = '0;
    a = x;
    for (int i = 0; i < 8; i++) begin
      if (y[i]) acc = acc ^ a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'hc3 : 8'h00);
    end
    return acc;
  endfunction

  // L as a matrix: 16 shift/feedback steps collapsed at elaboration-like constant coefs
  function automatic blk_t lmix(input blk_t x);
    logic [7:0] v [16];
    logic [7:0] t;
    blk_t o;
    for (int k = 0; k < 16; k++) v[k] = x[8*k +: 8];
    for (int r = 0; r < 16; r++) begin
      t = v[15];
      for (int j = 14; j >= 0; j--) begin
        v[j+1] = v[j];
        t = t ^ gmul(v[j], LCOEF[j]);
      end
      v[0] = t;
    end
    for (int k = 0; k < 16; k++) o[8*k +: 8] = v[k];
    return o;
  endfunction

  function automatic blk_t lmix_inv(input blk_t x);
    logic [7:0] v [16];
    logic [7:0] t;
    blk_t o;
    for (int k = 0; k < 16; k++) v[k] = x[8*k +: 8];
    for (int r = 0; r < 16; r++) begin
      t = v[0];
      for (int j = 0; j < 15; j++) begin
        v[j] = v[j+1];
        t = t ^ gmul(v[j], LCOEF[j]);
      end
      v[15] = t;
    end
    for (int k = 0; k < 16; k++) o[8*k +: 8] = v[k];
    return o;
  endfunction

  function automatic blk_t sub_fwd(input blk_t x);
    blk_t o;
    for (int k = 0; k < 16; k++) o[8*k +: 8] = SBOX[x[8*k +: 8]];
    return o;
  endfunction

  function automatic blk_t sub_inv(input blk_t x);
    blk_t o;
    for (int k = 0; k < 16; k++) o[8*k +: 8] = sbox_inv(x[8*k +: 8]);
    return o;
  endfunction

  function automatic blk_t kconst(input logic [5:0] i);
    return lmix({8'(i), 120'd0});
  endfunction

endpackage

[rtl/kuz_if.sv]
// Valid/ready channel interface for Kuznyechik requests and results.
// Depends on nothing.
interface kuz_in_if (input logic clk);
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [63:0] block_lo;
  logic [63:0] block_hi;
  modport source (output valid, req_type, block_lo, block_hi, input ready);
  modport sink   (input valid, req_type, block_lo, block_hi, output ready);
endinterface

interface kuz_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [63:0] result_lo;
  logic [63:0] result_hi;
  modport source (output valid, result_lo, result_hi, input ready);
  modport sink   (input valid, result_lo, result_hi, output ready);
endinterface

[rtl/kuz_key_sched.sv]
// Key schedule: one Feistel round per cycle, 32 rounds after each key write.
// Depends on kuz_pkg.
module kuz_key_sched (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [255:0]      key,
  output logic              busy,
  output kuz_pkg::blk_t     rk [kuz_pkg::NumRk]
);

  logic [5:0]    cnt_r, cnt_nxt;
  kuz_pkg::blk_t x_r, y_r, x_nxt, y_nxt;
  kuz_pkg::blk_t rk_r [kuz_pkg::NumRk];
  kuz_pkg::blk_t f;

  assign f = kuz_pkg::lmix(kuz_pkg::sub_fwd(x_r ^ kuz_pkg::kconst(cnt_r))) ^ y_r;

  always_comb begin
    cnt_nxt = cnt_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    if (start) begin
      cnt_nxt = 6'd1;
      x_nxt   = key[127:0];
      y_nxt   = key[255:128];
    end else if (cnt_r != 6'd0) begin
      x_nxt   = f;
      y_nxt   = x_r;
      cnt_nxt = (cnt_r == 6'(kuz_pkg::NumKsRounds)) ? 6'd0 : cnt_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 6'd1;
      x_r   <= '0;
      y_r   <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      x_r   <= x_nxt;
      y_r   <= y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rk_r[0] <= '0;
      rk_r[1] <= '0;
    end else if (start) begin
      rk_r[0] <= key[127:0];
      rk_r[1] <= key[255:128];
    end else if (cnt_r != 6'd0 && cnt_r[2:0] == 3'd0) begin
      rk_r[{cnt_r[5:3], 1'b0}] <= f;
      rk_r[{cnt_r[5:3], 1'b1}] <= x_r;
    end
  end

  assign busy = (cnt_r != 6'd0);
  assign rk   = rk_r;

endmodule

[rtl/kuz_round.sv]
// One pipeline stage: one cipher round for encrypt or decrypt, with valid/stall.
// Depends on kuz_pkg.
module kuz_round (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_in,
  input  logic          dec_in,
  input  kuz_pkg::blk_t d_in,
  input  kuz_pkg::blk_t k_enc,
  input  kuz_pkg::blk_t k_dec,
  output logic          v_out,
  output logic          dec_out,
  output kuz_pkg::blk_t d_out
);

  kuz_pkg::blk_t enc, dec;
  logic v_r;
  logic dec_r;
  kuz_pkg::blk_t d_r;

  // encrypt: x -> L(S(x ^ k)); decrypt: x -> S^-1(L^-1(x)) ^ k
  assign enc = kuz_pkg::lmix(kuz_pkg::sub_fwd(d_in ^ k_enc));
  assign dec = kuz_pkg::sub_inv(kuz_pkg::lmix_inv(d_in)) ^ k_dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dec_r <= dec_in;
      d_r   <= (dec_in == kuz_pkg::REQ_DEC) ? dec : enc;
    end
  end

  assign v_out   = v_r;
  assign dec_out = dec_r;
  assign d_out   = d_r;

endmodule

[rtl/kuznyechik_block_cipher.sv]
// Kuznyechik block cipher, 256-bit key, valid/ready request and result channels.
// From request accept to result valid: input stage, 9 rounds, final register.
// Throughput: one block per cycle; a stall holds the whole pipeline in place.
// Each key write reruns the key schedule, one Feistel round per cycle;
// requests are held off meanwhile. Reset (rst_n, synchronous) loads the zero key
// and runs the 32-round schedule before the first request.
module kuznyechik_block_cipher (
  input  logic                      clk,
  input  logic                      rst_n,
  kuz_in_if.sink                    in_ch,
  kuz_out_if.source                 out_ch,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [kuz_pkg::AddrW-1:0] cfg_paddr,
  input  logic [63:0]               cfg_pwdata,
  output logic [63:0]               cfg_prdata,
  output logic                      cfg_pready
);

  logic [63:0]   key_r [4];
  logic          wr;
  logic          wr_hit_r;
  logic          busy;
  logic          en;
  kuz_pkg::blk_t rk [kuz_pkg::NumRk];
  logic          v   [kuz_pkg::NumRounds+2];
  logic          dec [kuz_pkg::NumRounds+2];
  kuz_pkg::blk_t d   [kuz_pkg::NumRounds+2];
  logic          v_fin_r;
  kuz_pkg::blk_t d_fin_r;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
      wr_hit_r <= 1'b0;
    end else begin
      wr_hit_r <= 1'b0;
      if (wr) begin
        case (cfg_paddr)
          kuz_pkg::AddrKey0: begin key_r[0] <= cfg_pwdata; wr_hit_r <= 1'b1; end
          kuz_pkg::AddrKey1: begin key_r[1] <= cfg_pwdata; wr_hit_r <= 1'b1; end
          kuz_pkg::AddrKey2: begin key_r[2] <= cfg_pwdata; wr_hit_r <= 1'b1; end
          kuz_pkg::AddrKey3: begin key_r[3] <= cfg_pwdata; wr_hit_r <= 1'b1; end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (cfg_paddr)
      kuz_pkg::AddrKey0: cfg_prdata = key_r[0];
      kuz_pkg::AddrKey1: cfg_prdata = key_r[1];
      kuz_pkg::AddrKey2: cfg_prdata = key_r[2];
      kuz_pkg::AddrKey3: cfg_prdata = key_r[3];
      default:           cfg_prdata = '0;
    endcase
  end

  kuz_key_sched u_ks (
    .clk   (clk),
    .rst_n (rst_n),
    .start (wr_hit_r),
    .key   ({key_r[3], key_r[2], key_r[1], key_r[0]}),
    .busy  (busy),
    .rk    (rk)
  );

  assign en = !v_fin_r || out_ch.ready;
  assign in_ch.ready = en && !busy && !wr_hit_r;

  // input stage: decrypt starts with the last round key
  logic          v0_r, dec0_r;
  kuz_pkg::blk_t d0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_ch.valid && in_ch.ready;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dec0_r <= in_ch.req_type;
      d0_r   <= (in_ch.req_type == kuz_pkg::REQ_DEC) ?
                ({in_ch.block_hi, in_ch.block_lo} ^ rk[kuz_pkg::NumRk-1]) :
                {in_ch.block_hi, in_ch.block_lo};
    end
  end
  assign v[0]   = v0_r;
  assign dec[0] = dec0_r;
  assign d[0]   = d0_r;

  for (genvar g = 0; g < kuz_pkg::NumRounds; g++) begin : g_rnd
    kuz_round u_rnd (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .v_in    (v[g]),
      .dec_in  (dec[g]),
      .d_in    (d[g]),
      .k_enc   (rk[g]),
      .k_dec   (rk[kuz_pkg::NumRounds-1-g]),
      .v_out   (v[g+1]),
      .dec_out (dec[g+1]),
      .d_out   (d[g+1])
    );
  end

  assign v[kuz_pkg::NumRounds+1]   = 1'b0;
  assign dec[kuz_pkg::NumRounds+1] = 1'b0;
  assign d[kuz_pkg::NumRounds+1]   = '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_fin_r <= 1'b0;
    end else if (en) begin
      v_fin_r <= v[kuz_pkg::NumRounds] | v[kuz_pkg::NumRounds+1] | dec[kuz_pkg::NumRounds+1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d_fin_r <= (dec[kuz_pkg::NumRounds] == kuz_pkg::REQ_DEC) ?
                 (d[kuz_pkg::NumRounds] | d[kuz_pkg::NumRounds+1]) :
                 (d[kuz_pkg::NumRounds] ^ rk[kuz_pkg::NumRk-1]);
    end
  end

  assign out_ch.valid     = v_fin_r;
  assign out_ch.result_lo = d_fin_r[63:0];
  assign out_ch.result_hi = d_fin_r[127:64];

endmodule
